>>> rtl/brl_pkg.sv
// Shared types, constants and the dot map for the braille dot framebuffer.
// Used by the front end, the back end and the top level; depends on nothing.
`default_nettype none

package brl_pkg;

  localparam int unsigned ActionW  = 2;
  localparam int unsigned PosW     = 11;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned ColsRegW = 8;
  localparam int unsigned RowsRegW = 7;
  localparam int unsigned CellColW = 7;
  localparam int unsigned CellRowW = 6;
  localparam int unsigned CodeW    = 14;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned DotsW    = 8;
  // Command coordinates are wide enough for the largest screen a build allows.
  localparam int unsigned CmdColW  = 8;
  localparam int unsigned CmdRowW  = 8;

  localparam int unsigned RenderLimit = 64;
  localparam int unsigned RenderCntW  = $clog2(RenderLimit);

  localparam logic [ColsRegW-1:0] ColsReset   = 8'd80;
  localparam logic [RowsRegW-1:0] RowsReset   = 7'd24;
  localparam logic [CodeW-1:0]    BrailleBase = 14'h2800;
  localparam logic [DotsW-1:0]    FullDots    = 8'hFF;

  // Input actions.
  localparam logic [ActionW-1:0] ActSetDot = 2'd0;
  localparam logic [ActionW-1:0] ActFill   = 2'd1;
  localparam logic [ActionW-1:0] ActRender = 2'd2;
  localparam logic [ActionW-1:0] ActClear  = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgCols = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRows = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] StatDone    = 3'd0;
  localparam logic [StatusW-1:0] StatOutside = 3'd1;
  localparam logic [StatusW-1:0] StatFull    = 3'd2;
  localparam logic [StatusW-1:0] StatRender  = 3'd3;
  localparam logic [StatusW-1:0] StatEmpty   = 3'd4;

  typedef enum logic [2:0] {
    CMD_SETDOT  = 3'd0,
    CMD_FILL    = 3'd1,
    CMD_RENDER  = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_OUTSIDE = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [CmdColW-1:0] col;
    logic [CmdRowW-1:0] row;
    logic [DotsW-1:0]   dots;
  } brl_cmd_t;

  typedef struct packed {
    logic [CellColW-1:0] cell_col;
    logic [CellRowW-1:0] cell_row;
    logic [CodeW-1:0]    code_point;
    logic [StatusW-1:0]  status;
    logic                last;
  } brl_res_t;

  // Dot bit of a braille cell for the dot offset (dx, dy) inside the cell.
  function automatic logic [DotsW-1:0] dot_bit(input logic [1:0] dy, input logic dx);
    logic [DotsW-1:0] bits;
    case ({dy, dx})
      3'b000:  bits = 8'b0000_0001;
      3'b001:  bits = 8'b0000_1000;
      3'b010:  bits = 8'b0000_0010;
      3'b011:  bits = 8'b0001_0000;
      3'b100:  bits = 8'b0000_0100;
      3'b101:  bits = 8'b0010_0000;
      3'b110:  bits = 8'b0100_0000;
      default: bits = 8'b1000_0000;
    endcase
    return bits;
  endfunction

endpackage

`default_nettype wire

>>> rtl/braille_dot_framebuffer_top.sv
// Braille dot framebuffer top level: front end, command queue, back end and
// result queue. Depends on brl_pkg, brl_fifo, brl_front and brl_back.
//
// Usage: items go in on the push/full queue port (action, pos_x, pos_y) and
// results come out on the empty/pop queue port (cell_col, cell_row,
// code_point, status, last). The screen size registers are written through
// the cfg_valid_i/cfg_ready_o channel, index 0 for columns and 1 for rows,
// and must only change while the block is idle.
// A dot write or a fill gives one result: the idle state takes the command
// and reads the cell, then S_WMOD writes the cell back and pushes the
// result, waiting while the result queue is full, so a new command is taken
// only after that write-back. A render takes the command, then for each
// popped cell steps through stack read, cell read and emit, at most 64 per
// render. A clear sweeps the whole cell memory, one cell per cycle, then
// gives one result. Out-of-screen writes and empty renders go from the idle
// state straight to an emit of their result.
// After reset, full stays high while the cell memory is cleared;
// configuration writes are still taken then.
// A stalled receiver fills the two-entry result queue and then holds the
// sequencer; the two-entry command queue then fills and full rises.
`default_nettype none

module braille_dot_framebuffer_top #(
  parameter int unsigned MAX_COLS    = 128,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned DIRTY_DEPTH = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [brl_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [brl_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [brl_pkg::ActionW-1:0]     action_i,
  input  wire logic signed [brl_pkg::PosW-1:0] pos_x_i,
  input  wire logic signed [brl_pkg::PosW-1:0] pos_y_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [brl_pkg::CellColW-1:0]         cell_col_o,
  output logic [brl_pkg::CellRowW-1:0]         cell_row_o,
  output logic [brl_pkg::CodeW-1:0]            code_point_o,
  output logic [brl_pkg::StatusW-1:0]          status_o,
  output logic                                 last_o
);

  import brl_pkg::*;

  localparam int unsigned QueueDepth = 2;

  brl_cmd_t cmd_in, cmd_head;
  brl_res_t res_in, res_head;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic     res_push, res_full;
  logic     init_busy;

  brl_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .full_o     (full),
    .action_i   (action_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .cmd_full_i (cmd_full),
    .busy_i     (init_busy),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  brl_fifo #(
    .DataW($bits(brl_cmd_t)),
    .Depth(QueueDepth)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .data_o (cmd_head)
  );

  brl_back #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .DIRTY_DEPTH(DIRTY_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in),
    .init_busy_o(init_busy)
  );

  brl_fifo #(
    .DataW($bits(brl_res_t)),
    .Depth(QueueDepth)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_head)
  );

  assign cell_col_o   = res_head.cell_col;
  assign cell_row_o   = res_head.cell_row;
  assign code_point_o = res_head.code_point;
  assign status_o     = res_head.status;
  assign last_o       = res_head.last;

endmodule

`default_nettype wire

>>> rtl/brl_fifo.sv
// Small synchronous queue used between the front and back ends and on the
// result side. Self-contained; no package dependency.
`default_nettype none

module brl_fifo #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [DataW-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [DataW-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/brl_front.sv
// Front end: screen size registers, input acceptance and command classification.
// Depends on brl_pkg; feeds the command queue in front of brl_back.
`default_nettype none

module brl_front #(
  parameter int unsigned MAX_COLS = 128,
  parameter int unsigned MAX_ROWS = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [brl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [brl_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic [brl_pkg::ActionW-1:0]    action_i,
  input  wire logic signed [brl_pkg::PosW-1:0] pos_x_i,
  input  wire logic signed [brl_pkg::PosW-1:0] pos_y_i,
  input  wire logic                           cmd_full_i,
  input  wire logic                           busy_i,
  output logic                                cmd_push_o,
  output brl_pkg::brl_cmd_t                   cmd_o
);

  import brl_pkg::*;

  localparam logic [9:0] MaxColsC = 10'(MAX_COLS);
  localparam logic [9:0] MaxRowsC = 10'(MAX_ROWS);

  logic [ColsRegW-1:0] cols_q;
  logic [RowsRegW-1:0] rows_q;
  logic [9:0]          col_full, row_full;
  logic                on_screen, is_write;
  cmd_kind_e           kind;
  logic [DotsW-1:0]    dots;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ColsReset;
      rows_q <= RowsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgCols: cols_q <= cfg_data_i;
        CfgRows: rows_q <= cfg_data_i[RowsRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_full = '0;
    row_full = '0;
    dots     = '0;
    is_write = 1'b0;
    kind     = CMD_CLEAR;
    unique case (action_i)
      ActSetDot: begin
        // A dot at (x, y) lands in cell (x/2, y/4); negatives are caught below.
        col_full = {1'b0, pos_x_i[9:1]};
        row_full = {2'b0, pos_y_i[9:2]};
        dots     = dot_bit(pos_y_i[1:0], pos_x_i[0]);
        is_write = 1'b1;
        kind     = CMD_SETDOT;
      end
      ActFill: begin
        col_full = pos_x_i[9:0];
        row_full = pos_y_i[9:0];
        is_write = 1'b1;
        kind     = CMD_FILL;
      end
      ActRender: kind = CMD_RENDER;
      ActClear:  kind = CMD_CLEAR;
      default:   kind = CMD_CLEAR;
    endcase
  end

  assign on_screen = !pos_x_i[PosW-1] && !pos_y_i[PosW-1]
                     && (col_full < {2'b0, cols_q}) && (col_full < MaxColsC)
                     && (row_full < {3'b0, rows_q}) && (row_full < MaxRowsC);

  assign full_o     = cmd_full_i || busy_i;
  assign cmd_push_o = push_i && !full_o;

  always_comb begin
    cmd_o.kind = (is_write && !on_screen) ? CMD_OUTSIDE : kind;
    cmd_o.col  = CmdColW'(col_full);
    cmd_o.row  = CmdRowW'(row_full);
    cmd_o.dots = dots;
  end

endmodule

`default_nettype wire

>>> rtl/brl_back.sv
// Back end: cell memory, dirty stack and the sequencer that carries out commands.
// Depends on brl_pkg; takes commands from a queue and pushes results into one.
`default_nettype none

module brl_back #(
  parameter int unsigned MAX_COLS    = 128,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned DIRTY_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_empty_i,
  input  wire brl_pkg::brl_cmd_t cmd_i,
  output logic             cmd_pop_o,
  input  wire logic        res_full_i,
  output logic             res_push_o,
  output brl_pkg::brl_res_t res_o,
  output logic             init_busy_o
);

  import brl_pkg::*;

  localparam int unsigned CellDepth = MAX_COLS * MAX_ROWS;
  localparam int unsigned CellAw    = $clog2(CellDepth);
  localparam int unsigned ColW      = $clog2(MAX_COLS);
  localparam int unsigned RowW      = $clog2(MAX_ROWS);
  localparam int unsigned IdxW      = $clog2(DIRTY_DEPTH);
  localparam int unsigned CntW      = $clog2(DIRTY_DEPTH + 1);
  localparam int unsigned EntW      = ColW + RowW;

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_WMOD  = 8'b0000_0100,
    S_RPOP  = 8'b0000_1000,
    S_RCELL = 8'b0001_0000,
    S_REMIT = 8'b0010_0000,
    S_CLEAR = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [RenderCntW-1:0] n_q, n_d;
  logic [CellAw-1:0]   clr_q, clr_d;
  logic [StatusW-1:0]  stat_q, stat_d;
  brl_cmd_t            cmd_q;

  logic [DotsW-1:0]    cell_mem [CellDepth];
  logic [DotsW-1:0]    cell_rd_q;
  logic                cell_we, cell_re;
  logic [CellAw-1:0]   cell_wa, cell_ra;
  logic [DotsW-1:0]    cell_wd;

  logic [EntW-1:0]     stk_mem [DIRTY_DEPTH];
  logic [EntW-1:0]     stk_rd_q;
  logic                stk_we, stk_re;
  logic [IdxW-1:0]     stk_ra;

  logic [ColW-1:0]     cmd_col, ent_col;
  logic [RowW-1:0]     cmd_row, ent_row, head_row;
  logic [ColW-1:0]     head_col;
  logic [CellAw-1:0]   head_addr, cmd_addr, ent_addr;
  logic [DotsW-1:0]    new_dots;
  logic                stk_room, render_last;
  logic [CntW-1:0]     count_dec;

  assign head_col  = ColW'(cmd_i.col);
  assign head_row  = RowW'(cmd_i.row);
  assign cmd_col   = ColW'(cmd_q.col);
  assign cmd_row   = RowW'(cmd_q.row);
  assign ent_col   = stk_rd_q[ColW-1:0];
  assign ent_row   = stk_rd_q[EntW-1:ColW];
  assign head_addr = CellAw'(head_row) * CellAw'(MAX_COLS) + CellAw'(head_col);
  assign cmd_addr  = CellAw'(cmd_row) * CellAw'(MAX_COLS) + CellAw'(cmd_col);
  assign ent_addr  = CellAw'(ent_row) * CellAw'(MAX_COLS) + CellAw'(ent_col);

  assign new_dots    = (cmd_q.kind == CMD_FILL) ? FullDots : (cell_rd_q | cmd_q.dots);
  assign stk_room    = (count_q != CntW'(DIRTY_DEPTH));
  assign count_dec   = count_q - 1'b1;
  // A render stops when the stack runs dry or after the per-render limit.
  assign render_last = (count_q == '0) || (n_q == RenderCntW'(RenderLimit - 1));
  assign init_busy_o = (state_q == S_INIT);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    n_d        = n_q;
    clr_d      = clr_q;
    stat_d     = stat_q;
    cmd_pop_o  = 1'b0;
    cell_we    = 1'b0;
    cell_re    = 1'b0;
    cell_wa    = cmd_addr;
    cell_ra    = head_addr;
    cell_wd    = new_dots;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    stk_ra     = count_dec[IdxW-1:0];
    res_push_o = 1'b0;
    res_o.cell_col   = '0;
    res_o.cell_row   = '0;
    res_o.code_point = BrailleBase;
    res_o.status     = stat_q;
    res_o.last       = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_OUTSIDE: begin
              stat_d  = StatOutside;
              state_d = S_EMIT;
            end
            CMD_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            CMD_RENDER: begin
              if (count_q == '0) begin
                stat_d  = StatEmpty;
                state_d = S_EMIT;
              end else begin
                n_d     = '0;
                state_d = S_RPOP;
              end
            end
            default: begin
              cell_re = 1'b1;
              cell_ra = head_addr;
              state_d = S_WMOD;
            end
          endcase
        end
      end
      S_WMOD: begin
        res_o.cell_col   = CellColW'(cmd_col);
        res_o.cell_row   = CellRowW'(cmd_row);
        res_o.code_point = BrailleBase | CodeW'(new_dots);
        res_o.status     = stk_room ? StatDone : StatFull;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          cell_we    = 1'b1;
          cell_wa    = cmd_addr;
          cell_wd    = new_dots;
          if (stk_room) begin
            stk_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_RPOP: begin
        stk_re  = 1'b1;
        stk_ra  = count_dec[IdxW-1:0];
        count_d = count_dec;
        state_d = S_RCELL;
      end
      S_RCELL: begin
        cell_re = 1'b1;
        cell_ra = ent_addr;
        state_d = S_REMIT;
      end
      S_REMIT: begin
        res_o.cell_col   = CellColW'(ent_col);
        res_o.cell_row   = CellRowW'(ent_row);
        res_o.code_point = BrailleBase | CodeW'(cell_rd_q);
        res_o.status     = StatRender;
        res_o.last       = render_last;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          n_d        = n_q + 1'b1;
          state_d    = render_last ? S_IDLE : S_RPOP;
        end
      end
      S_INIT, S_CLEAR: begin
        cell_we = 1'b1;
        cell_wa = clr_q;
        cell_wd = '0;
        if (clr_q == CellAw'(CellDepth - 1)) begin
          clr_d = '0;
          if (state_q == S_INIT) begin
            state_d = S_IDLE;
          end else begin
            stat_d  = StatDone;
            state_d = S_EMIT;
          end
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      count_q <= '0;
      n_q     <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_wa] <= cell_wd;
    end
    if (cell_re) begin
      cell_rd_q <= cell_mem[cell_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[count_q[IdxW-1:0]] <= {cmd_row, cmd_col};
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DIRTY_DEPTH))
    else $error("dirty count beyond stack depth");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RPOP) |-> (count_q != '0))
    else $error("render popped an empty dirty stack");

  a_render_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REMIT && res_push_o && res_o.last) |=> (state_q == S_IDLE))
    else $error("render continued after its last result");
`endif

endmodule

`default_nettype wire
